[src/fdd_pkg.sv]
// Shared types and constants for the fraction decimal digit divider.
// No dependencies; every other file imports this package.
`default_nettype none
package fdd_pkg;

    localparam int VALUE_W      = 31;  // dividend, divisor, quotient width
    localparam int COUNT_W      = 7;   // digit count width
    localparam int WIDE_W       = 35;  // remainder times ten
    localparam int FRAC_BITS    = 4;   // quotient bits of one decimal digit
    localparam int STEP_W       = 5;   // holds up to VALUE_W steps
    localparam int RADIX        = 10;
    localparam int MAX_DIGITS_D = 64;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } fdd_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_first;  // take a new item, clear quotient
        logic load_frac;   // scale remainder by ten for the next digit
        logic step;        // one restoring division step
    } fdd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_zero;    // divisor of the incoming item is zero
    } fdd_status_t;

endpackage
`default_nettype wire

[src/fdd_if.sv]
// Handshake interfaces for request and result items.
// Depends on fdd_pkg for field widths.
`default_nettype none
interface fdd_req_if import fdd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   dividend;
    logic [VALUE_W-1:0]   divisor;
    logic [COUNT_W-1:0]   digit_count;

    modport source (output valid, dividend, divisor, digit_count, input ready);
    modport sink   (input valid, dividend, divisor, digit_count, output ready);
endinterface

interface fdd_res_if import fdd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   digit_value;
    logic                 last_of_run;
    logic                 divide_error;

    modport source (output valid, digit_value, last_of_run, divide_error, input ready);
    modport sink   (input valid, digit_value, last_of_run, divide_error, output ready);
endinterface
`default_nettype wire

[src/fdd_datapath.sv]
// Datapath: remainder, numerator shift register, quotient and divisor registers
// with one restoring subtract per cycle while step is set. Depends on fdd_pkg.
`default_nettype none
module fdd_datapath import fdd_pkg::*;
(
    input  wire logic               clk,
    input  wire fdd_cmd_t           cmd,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [VALUE_W-1:0] divisor,
    output fdd_status_t             status,
    output logic [VALUE_W-1:0]      quotient
);

    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0] num_reg, num_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [VALUE_W-1:0] div_reg, div_next;
    logic [VALUE_W:0]   shifted;
    logic [VALUE_W:0]   trial;
    logic [WIDE_W-1:0]  scaled;

    assign status.div_zero = (divisor == '0);
    assign quotient        = quo_reg;

    // trial subtract of the divisor from the remainder with next bit shifted in
    assign shifted = {rem_reg, num_reg[VALUE_W-1]};
    assign trial   = shifted - {1'b0, div_reg};

    // remainder times ten; remainder < divisor so the product fits
    assign scaled = WIDE_W'(rem_reg) * WIDE_W'(RADIX);

    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        priority if (cmd.load_first)
        begin
            rem_next = '0;
            num_next = dividend;
            quo_next = '0;
            div_next = divisor;
        end
        else if (cmd.load_frac)
        begin
            // upper part starts as remainder, low four bits still to shift in
            rem_next = scaled[WIDE_W-1:FRAC_BITS];
            num_next = {scaled[FRAC_BITS-1:0], {(VALUE_W-FRAC_BITS){1'b0}}};
            quo_next = '0;
        end
        else if (cmd.step)
        begin
            num_next = {num_reg[VALUE_W-2:0], 1'b0};
            if (!trial[VALUE_W])
            begin
                rem_next = trial[VALUE_W-1:0];
                quo_next = {quo_reg[VALUE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VALUE_W-1:0];
                quo_next = {quo_reg[VALUE_W-2:0], 1'b0};
            end
        end
        else
        begin
            // no command: all registers hold
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule
`default_nettype wire

[src/fdd_controller.sv]
// Controller: sequences one request through its digits, counts division
// steps and remaining digits, and runs both handshakes. Depends on fdd_pkg.
`default_nettype none
module fdd_controller import fdd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_D
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [COUNT_W-1:0] digit_count,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_last,
    output logic                    out_error,
    input  wire fdd_status_t        status,
    output fdd_cmd_t                cmd
);

    fdd_state_t         state_reg, state_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic               err_reg, err_next;
    logic [COUNT_W-1:0] count_sat;

    // zero digit count means one, large counts clip to the maximum
    always_comb
    begin
        priority if (digit_count == '0)
            count_sat = COUNT_W'(1);
        else if (digit_count > COUNT_W'(MAX_DIGITS))
            count_sat = COUNT_W'(MAX_DIGITS);
        else
            count_sat = digit_count;
    end

    assign out_last  = err_reg || (left_reg == COUNT_W'(1));
    assign out_error = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            steps_reg <= '0;
            left_reg  <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            steps_reg <= steps_next;
            left_reg  <= left_next;
            err_reg   <= err_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        steps_next = steps_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_first = 1'b1;
                    left_next      = count_sat;
                    steps_next     = STEP_W'(VALUE_W);
                    err_next       = status.div_zero;
                    state_next     = status.div_zero ? ST_EMIT : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step   = 1'b1;
                steps_next = steps_reg - STEP_W'(1);
                if (steps_reg == STEP_W'(1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (out_last)
                    begin
                        left_next  = '0;
                        err_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load_frac = 1'b1;
                        left_next     = left_reg - COUNT_W'(1);
                        steps_next    = STEP_W'(FRAC_BITS);
                        state_next    = ST_DIVIDE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/fraction_decimal_digit_divider.sv]
// Top level of the fraction decimal digit divider: controller plus datapath.
// Depends on fdd_pkg, fdd_if, fdd_controller and fdd_datapath.
//
// Expands dividend/divisor by long division. A request of dividend, divisor
// and digit_count yields digit_count results (0 taken as 1, clipped at
// MAX_DIGITS): first the integer quotient, then one decimal fraction digit
// each, the final one marked by last_of_run. A zero divisor gives a single
// result of value 0 with divide_error and last_of_run set. One request is
// handled at a time. Timing is set by a single shared restoring-division
// unit that retires one quotient bit per cycle while in the divide state;
// the integer quotient has 31 bits and each fraction digit 4, and each
// result is held until the sink accepts it, which stalls the division.
`default_nettype none
module fraction_decimal_digit_divider import fdd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_D
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    fdd_req_if.sink   req,
    fdd_res_if.source res
);

    fdd_cmd_t    cmd;
    fdd_status_t status;

    fdd_controller #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .digit_count (req.digit_count),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .out_last    (res.last_of_run),
        .out_error   (res.divide_error),
        .status      (status),
        .cmd         (cmd)
    );

    fdd_datapath u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .dividend (req.dividend),
        .divisor  (req.divisor),
        .status   (status),
        .quotient (res.digit_value)
    );

endmodule
`default_nettype wire

[bench/tb_fraction_decimal_digit_divider.sv]
// Testbench for fraction_decimal_digit_divider: directed table, then random requests.
// Results are checked against a behavioral long-division predictor.
// Depends on fdd_pkg, fdd_if and the divider RTL.
`default_nettype none
module tb_fraction_decimal_digit_divider import fdd_pkg::*;;

    localparam int RANDOM_ITEMS = 210;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int SHOWN_ERRORS = 10;
    localparam int DIRECTED_N   = 20;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // one result item
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               err;
    } digit_t;

    // one row of the directed table; typed rows carry a single expected result
    typedef struct packed {
        logic [VALUE_W-1:0] dividend;
        logic [VALUE_W-1:0] divisor;
        logic [COUNT_W-1:0] count;
        logic               typed;
        logic [VALUE_W-1:0] typed_value;
        logic               typed_err;
    } request_row_t;

    logic clk;
    logic rst_n;

    fdd_req_if req_ch ();
    fdd_res_if res_ch ();

    fraction_decimal_digit_divider dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    digit_t pending_digits [$];
    int     mismatches;
    int     digits_checked;
    int     requests_sent;
    int     zero_div_requests;
    logic   steady;

    // directed table: extremes, zero divisor, zero and oversized counts
    request_row_t directed_rows [DIRECTED_N] = '{
        '{31'd0,      31'd0,         7'd0,   1'b1, 31'd0,     1'b1},
        '{VALUE_MAX,  31'd0,         7'd64,  1'b1, 31'd0,     1'b1},
        '{31'd5,      31'd0,         7'd127, 1'b1, 31'd0,     1'b1},
        '{VALUE_MAX,  31'd1,         7'd1,   1'b1, VALUE_MAX, 1'b0},
        '{VALUE_MAX,  VALUE_MAX,     7'd1,   1'b1, 31'd1,     1'b0},
        '{31'd0,      VALUE_MAX,     7'd0,   1'b1, 31'd0,     1'b0},
        '{31'd7,      31'd2,         7'd0,   1'b1, 31'd3,     1'b0},
        '{31'd1,      31'd3,         7'd10,  1'b0, 31'd0,     1'b0},
        '{31'd22,     31'd7,         7'd64,  1'b0, 31'd0,     1'b0},
        '{31'd1,      31'd7,         7'd127, 1'b0, 31'd0,     1'b0},
        '{31'd100,    31'd3,         7'd65,  1'b0, 31'd0,     1'b0},
        '{VALUE_MAX,  VALUE_MAX - 1, 7'd20,  1'b0, 31'd0,     1'b0},
        '{31'd1,      VALUE_MAX,     7'd64,  1'b0, 31'd0,     1'b0},
        '{31'd10,     31'd4,         7'd5,   1'b0, 31'd0,     1'b0},
        '{31'd0,      31'd1,         7'd8,   1'b0, 31'd0,     1'b0},
        '{VALUE_MAX - 1, VALUE_MAX,  7'd30,  1'b0, 31'd0,     1'b0},
        '{31'd1,      31'd2,         7'd2,   1'b0, 31'd0,     1'b0},
        '{31'h55555555, 31'h2AAAAAAA, 7'd12, 1'b0, 31'd0,     1'b0},
        '{31'h2AAAAAAA, 31'd3,       7'd6,   1'b0, 31'd0,     1'b0},
        '{VALUE_MAX,  31'd10,        7'd3,   1'b0, 31'd0,     1'b0}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // timeout
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still expected",
                 CYCLE_LIMIT, pending_digits.size());
        $display("tb_fraction_decimal_digit_divider NOT OK");
        $finish;
    end

    // long division: push every digit the request should produce
    task automatic expand_fraction(input logic [VALUE_W-1:0] dvd,
                                   input logic [VALUE_W-1:0] dvs,
                                   input logic [COUNT_W-1:0] cnt);
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] quo;
        logic [WIDE_W-1:0] rem;
        int                n;
        digit_t            d;
        n = cnt;
        if (n == 0)
            n = 1;
        if (n > MAX_DIGITS_D)
            n = MAX_DIGITS_D;
        if (dvs == '0)
        begin
            d.value = '0;
            d.last  = 1'b1;
            d.err   = 1'b1;
            pending_digits.push_back(d);
            zero_div_requests++;
        end
        else
        begin
            num = WIDE_W'(dvd);
            for (int i = n; i > 0; i--)
            begin
                quo     = num / WIDE_W'(dvs);
                rem     = num % WIDE_W'(dvs);
                d.value = quo[VALUE_W-1:0];
                d.last  = (i == 1);
                d.err   = 1'b0;
                pending_digits.push_back(d);
                num     = rem * RADIX;
            end
        end
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // operand mix: zero, max, small, medium, full range
    function automatic logic [VALUE_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VALUE_MAX;
            2, 3, 4: return VALUE_W'($urandom_range(1, 20));
            5, 6:    return VALUE_W'($urandom_range(1, 1000));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // counts: mostly short runs, some long, a few zero or oversized
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return COUNT_W'($urandom_range(MAX_DIGITS_D + 1, 127));
        else if (r < 6)
            return COUNT_W'($urandom_range(9, MAX_DIGITS_D));
        else if (r == 6)
            return COUNT_W'(MAX_DIGITS_D);
        else
            return COUNT_W'($urandom_range(1, 8));
    endfunction

    // present one request and hold it until accepted, then record expectations
    task automatic send_request(input request_row_t row);
        int     gap;
        digit_t d;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.dividend    <= row.dividend;
        req_ch.divisor     <= row.divisor;
        req_ch.digit_count <= row.count;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
        if (row.typed)
        begin
            d.value = row.typed_value;
            d.last  = 1'b1;
            d.err   = row.typed_err;
            pending_digits.push_back(d);
            if (row.typed_err)
                zero_div_requests++;
        end
        else
            expand_fraction(row.dividend, row.divisor, row.count);
        if ($urandom_range(0, 29) == 0)
            steady = ~steady;
    endtask

    // reset and request driver
    initial
    begin
        request_row_t row;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.dividend    = '0;
        req_ch.divisor     = '0;
        req_ch.digit_count = '0;
        mismatches         = 0;
        digits_checked     = 0;
        requests_sent      = 0;
        zero_div_requests  = 0;
        steady             = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_request(directed_rows[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            row.dividend = pick_operand();
            if ($urandom_range(0, 15) == 0)
                row.divisor = '0;
            else
            begin
                row.divisor = pick_operand();
                if (row.divisor == '0)
                    row.divisor = VALUE_W'($urandom_range(1, 9));
            end
            row.count       = pick_count();
            row.typed       = 1'b0;
            row.typed_value = '0;
            row.typed_err   = 1'b0;
            send_request(row);
        end
        req_ch.valid <= 1'b0;

        // drain, then give stray results a chance to show up
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests (%0d with zero divisor), checked %0d result items",
                 requests_sent, zero_div_requests, digits_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_digits.size() == 0)
            $display("tb_fraction_decimal_digit_divider OK");
        else
            $display("tb_fraction_decimal_digit_divider NOT OK");
        $finish;
    end

    // result sink: ready in stretches, with random stalls between
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // result checker: compare each accepted item with the oldest expectation
    always @(posedge clk)
    begin
        digit_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_digits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result: value %0d last %0b err %0b",
                             res_ch.digit_value, res_ch.last_of_run, res_ch.divide_error);
            end
            else
            begin
                want = pending_digits.pop_front();
                digits_checked++;
                if (res_ch.digit_value !== want.value || res_ch.last_of_run !== want.last
                    || res_ch.divide_error !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("result %0d mismatch: value %0d/%0d last %0b/%0b err %0b/%0b",
                                 digits_checked, want.value, res_ch.digit_value,
                                 want.last, res_ch.last_of_run,
                                 want.err, res_ch.divide_error);
                end
            end
        end
    end
endmodule
`default_nettype wire

[sim.f]
src/fdd_pkg.sv
src/fdd_if.sv
src/fdd_datapath.sv
src/fdd_controller.sv
src/fraction_decimal_digit_divider.sv
bench/tb_fraction_decimal_digit_divider.sv
